// ----- rtl/core/rvx_pkg.sv -----
// Package: shared types and constants for the RV32IM execute block.
`timescale 1ns / 1ps
package rvx_pkg;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_FENCE  = 7'h0F;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MEM   = 2'd1;
  localparam logic [1:0] ST_ILLEG = 2'd2;

  localparam logic [0:0] REG_START = 1'b0;
  localparam logic [0:0] REG_STOP  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MDIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] instruction_address;
    logic [31:0] next_address;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_written;
    logic [1:0]  status;
    logic        halted;
  } result_t;
endpackage

// ----- rtl/core/rv32im_integer_execute.sv -----
// Top level: RV32IM execute block with register file and shared shift-add unit.
`timescale 1ns / 1ps
// Channel  | Direction | Content
// in_      | slave     | tdata[31:0] instruction
// out_     | master    | tdata: instruction_address, next_address, dest_index,
//          |           |   dest_value, dest_written, status, halted (low bit up)
// cfg_     | APB       | 0x0 start_address, 0x4 stop_address
// Flow: ALU, branch and jump items pass through read, execute and deliver.
// MUL/DIV/REM items add 32 radix-2 shift/add-subtract steps, then commit.
// Reset: synchronous; register file cleared by per-entry valid bits.
// A finished result waits in the output register; in_tready stays low until taken.
module rv32im_integer_execute (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // instruction
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // instruction_address, next_address, dest_index,
                                   // dest_value, dest_written, status, halted, zero pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import rvx_pkg::*;

  state_t state_r, state_nxt;
  logic [31:0] start_r, stop_r, pc_r;
  logic        halt_r;
  logic [31:0] rf_r [32];
  logic [31:0] rf_vld_r;
  logic [31:0] ins_r, a_r, b_r;
  result_t     res_r;
  logic        cfg_wr;

  // multiply/divide unit
  logic [31:0] acc_r, mq_r, md_r;   // acc: high/rem, mq: low/quotient
  logic [5:0]  cnt_r;
  logic        neg_r, is_div_r;
  logic [2:0]  mf3_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  always_comb begin
    case (cfg_paddr[2])
      REG_START: cfg_prdata = start_r;
      default:   cfg_prdata = stop_r;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata  = {7'b0, res_r.halted, res_r.status, res_r.dest_written,
                       res_r.dest_value, res_r.dest_index, res_r.next_address,
                       res_r.instruction_address};

  logic in_acc;
  assign in_acc = in_tvalid & in_tready;

  // decode of the held instruction
  logic [6:0] opc, f7;
  logic [2:0] f3;
  logic [4:0] rd;
  logic [31:0] immi, immb, immj, immu;
  assign opc = ins_r[6:0];
  assign rd  = ins_r[11:7];
  assign f3  = ins_r[14:12];
  assign f7  = ins_r[31:25];
  assign immi = {{20{ins_r[31]}}, ins_r[31:20]};
  assign immb = {{19{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
  assign immj = {{11{ins_r[31]}}, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};
  assign immu = {ins_r[31:12], 12'h000};

  logic is_md;
  assign is_md = (opc == OP_REG) && (f7 == 7'h01);

  // execute stage
  logic [31:0] opb, val, nxt, pc4;
  logic        wr, take;
  logic [1:0]  st;
  logic        slt_s, slt_u;
  always_comb begin
    opb = (opc == OP_REG || opc == OP_BRANCH) ? b_r : immi;
    pc4 = pc_r + 32'd4;
    slt_s = $signed(a_r) < $signed(opb);
    slt_u = a_r < opb;
    val = '0; wr = 1'b0; st = ST_OK; nxt = pc4; take = 1'b0;
    case (opc)
      OP_REG, OP_IMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: val = (opc == OP_REG && f7 == 7'h20) ? a_r - opb : a_r + opb;
          3'd1: val = a_r << opb[4:0];
          3'd2: val = {31'd0, slt_s};
          3'd3: val = {31'd0, slt_u};
          3'd4: val = a_r ^ opb;
          3'd5: val = f7[5] ? 32'($signed(a_r) >>> opb[4:0]) : a_r >> opb[4:0];
          3'd6: val = a_r | opb;
          default: val = a_r & opb;
        endcase
        if (opc == OP_REG) begin
          if (!(f7 == 7'h00 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))) begin
            wr = 1'b0; st = ST_ILLEG;
          end
        end else if (f3 == 3'd1 && f7 != 7'h00) begin
          wr = 1'b0; st = ST_ILLEG;
        end else if (f3 == 3'd5 && f7 != 7'h00 && f7 != 7'h20) begin
          wr = 1'b0; st = ST_ILLEG;
        end
      end
      OP_JALR: begin
        if (f3 == 3'd0) begin
          wr = 1'b1; val = pc4; nxt = (a_r + immi) & ~32'd1;
        end else st = ST_ILLEG;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: take = (a_r == b_r);
          3'd1: take = (a_r != b_r);
          3'd4: take = slt_s;
          3'd5: take = !slt_s;
          3'd6: take = slt_u;
          3'd7: take = !slt_u;
          default: st = ST_ILLEG;
        endcase
        if (take) nxt = pc_r + immb;
      end
      OP_JAL:   begin wr = 1'b1; val = pc4; nxt = pc_r + immj; end
      OP_LUI:   begin wr = 1'b1; val = immu; end
      OP_AUIPC: begin wr = 1'b1; val = pc_r + immu; end
      OP_FENCE: ;
      OP_LOAD, OP_STORE: st = ST_MEM;
      default: st = ST_ILLEG;
    endcase
  end

  // mul/div result selection
  logic [31:0] md_val;
  logic        b_zero, ovf;
  assign b_zero = (b_r == 32'd0);
  assign ovf = (a_r == 32'h80000000) && (b_r == 32'hFFFFFFFF);
  always_comb begin
    case (mf3_r)
      3'd0: md_val = neg_r ? ~mq_r + 32'd1 : mq_r;
      3'd1, 3'd2, 3'd3: md_val = neg_r ? ~acc_r + {31'd0, (mq_r == 32'd0)} : acc_r;
      3'd4: md_val = b_zero ? 32'hFFFFFFFF : (ovf ? 32'h80000000
                     : (neg_r ? 32'd0 - mq_r : mq_r));
      3'd5: md_val = b_zero ? 32'hFFFFFFFF : mq_r;
      3'd6: md_val = b_zero ? a_r : (ovf ? 32'd0 : (neg_r ? 32'd0 - acc_r : acc_r));
      default: md_val = b_zero ? a_r : acc_r;
    endcase
  end

  // one step of the shared shift/add-subtract unit
  logic [32:0] add_sum, sub_dif;
  logic [31:0] rem_sh;
  assign add_sum = {1'b0, acc_r} + ((mq_r[0]) ? {1'b0, md_r} : 33'd0);
  assign rem_sh  = {acc_r[30:0], mq_r[31]};
  assign sub_dif = {acc_r[31], rem_sh} - {1'b0, md_r};

  // operand magnitudes at entry
  logic        sa_neg, sb_neg;
  logic [31:0] ma, mb;
  always_comb begin
    sa_neg = 1'b0; sb_neg = 1'b0;
    case (f3)
      3'd1, 3'd4, 3'd6: begin sa_neg = a_r[31]; sb_neg = b_r[31]; end
      3'd2: sa_neg = a_r[31];
      default: ;
    endcase
    ma = sa_neg ? 32'd0 - a_r : a_r;
    mb = sb_neg ? 32'd0 - b_r : b_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_EXEC;
      S_EXEC: state_nxt = (is_md && !halt_r) ? S_MDIV : S_DONE;
      S_MDIV: if (cnt_r == 6'd32) state_nxt = S_DONE;
      S_DONE: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic        commit;
  logic [31:0] c_val, c_nxt;
  logic        c_wr;
  logic [1:0]  c_st;
  always_comb begin
    commit = 1'b0;
    c_val = val; c_nxt = nxt; c_wr = wr; c_st = st;
    if (state_r == S_EXEC && !(is_md && !halt_r)) commit = 1'b1;
    if (state_r == S_MDIV && cnt_r == 6'd32) begin
      commit = 1'b1; c_val = md_val; c_nxt = pc_r + 32'd4; c_wr = 1'b1; c_st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= '0; stop_r <= '0; pc_r <= '0; halt_r <= 1'b0;
      rf_vld_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[2])
          REG_START: begin start_r <= cfg_pwdata; pc_r <= cfg_pwdata; halt_r <= 1'b0; end
          default:   stop_r <= cfg_pwdata;
        endcase
      end
      if (state_r == S_EXEC) cnt_r <= '0;
      else if (state_r == S_MDIV) cnt_r <= cnt_r + 6'd1;
      if (commit && !halt_r) begin
        pc_r <= c_nxt;
        halt_r <= (c_nxt == stop_r);
        if (c_wr && rd != 5'd0) rf_vld_r[rd] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) ins_r <= in_tdata;
    if (commit && !halt_r && c_wr && rd != 5'd0) rf_r[rd] <= c_val;
    if (commit) begin
      res_r.instruction_address <= pc_r;
      if (halt_r) begin
        res_r.next_address <= pc_r; res_r.dest_index <= '0; res_r.dest_value <= '0;
        res_r.dest_written <= 1'b0; res_r.status <= ST_OK; res_r.halted <= 1'b1;
      end else begin
        res_r.next_address <= c_nxt;
        res_r.dest_index   <= (c_wr && rd != 5'd0) ? rd : 5'd0;
        res_r.dest_value   <= (c_wr && rd != 5'd0) ? c_val : 32'd0;
        res_r.dest_written <= c_wr && rd != 5'd0;
        res_r.status       <= c_st;
        res_r.halted       <= (c_nxt == stop_r);
      end
    end
    // mul/div unit
    if (state_r == S_EXEC) begin
      mf3_r    <= f3;
      is_div_r <= f3[2];
      acc_r    <= '0;
      mq_r     <= f3[2] ? ma : mb;
      md_r     <= f3[2] ? mb : ma;
      neg_r    <= (f3 == 3'd6) ? sa_neg : (sa_neg ^ sb_neg);
    end else if (state_r == S_MDIV) begin
      if (!is_div_r) begin
        {acc_r, mq_r} <= {add_sum, mq_r[31:1]};
      end else if (!sub_dif[32]) begin
        acc_r <= sub_dif[31:0];
        mq_r  <= {mq_r[30:0], 1'b1};
      end else begin
        acc_r <= rem_sh;
        mq_r  <= {mq_r[30:0], 1'b0};
      end
    end
  end

  // read both operands in the accept cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r <= (rf_vld_r[in_tdata[19:15]] && in_tdata[19:15] != 5'd0)
             ? rf_r[in_tdata[19:15]] : 32'd0;
      b_r <= (rf_vld_r[in_tdata[24:20]] && in_tdata[24:20] != 5'd0)
             ? rf_r[in_tdata[24:20]] : 32'd0;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accept while busy");
  a_x0_never: assert property (@(posedge clk) disable iff (!rst_n)
    !rf_vld_r[0]) else $error("x0 marked written");
  a_md_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MDIV && $past(state_r) == S_EXEC) |-> cnt_r == 6'd0)
    else $error("mul/div count not cleared");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_tready) |=> state_r == S_DONE) else $error("result dropped");
endmodule
